[src/gbba_pkg.sv]
// ----------------------------------------------------------------------------
// gbba_pkg
// Shared types, sizes and codes of the grouped bitmap block allocator.
// ----------------------------------------------------------------------------
package gbba_pkg;

    localparam int GROUPS          = 16;
    localparam int BITS_PER_GROUP  = 8192;
    localparam int WORD_BITS       = 32;
    localparam int WORDS_PER_GROUP = BITS_PER_GROUP / WORD_BITS;
    localparam int GRP_W           = $clog2(GROUPS);
    localparam int WIDX_W          = $clog2(WORDS_PER_GROUP);
    localparam int BIT_W           = $clog2(WORD_BITS);
    localparam int ADDR_W          = GRP_W + WIDX_W;
    localparam int DEPTH           = GROUPS * WORDS_PER_GROUP;
    localparam int GCNT_W          = 14;
    localparam int TOT_W           = 18;
    localparam int NG_W            = 5;
    localparam int CFG_IDX_W       = 2;

    localparam logic [2:0] KIND_ALLOC     = 3'd0;
    localparam logic [2:0] KIND_FREE      = 3'd1;
    localparam logic [2:0] KIND_LOAD_WORD = 3'd2;
    localparam logic [2:0] KIND_LOAD_GCNT = 3'd3;
    localparam logic [2:0] KIND_LOAD_TOT  = 3'd4;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_IS_FREE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BPG        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUPS     = 2'd3;

    typedef struct packed {
        logic [2:0]        kind;
        logic [TOT_W-1:0]  block_number;
        logic [3:0]        group;
        logic [7:0]        word_index;
        logic [31:0]       load_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [TOT_W-1:0]  block_number_res;
        logic [TOT_W-1:0]  total_free;
    } out_item_t;

    typedef struct packed {
        logic              data_start;
        logic [GCNT_W-1:0] group_size;
        logic [TOT_W-1:0]  total_blocks;
        logic [NG_W-1:0]   groups_in_use;
    } cfg_t;

    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    addr;
        logic [WORD_BITS-1:0] wdata;
    } mem_req_t;

endpackage

[src/gbba_bitmap_ram.sv]
// ----------------------------------------------------------------------------
// gbba_bitmap_ram
// Single-port bitmap store, registered read.
// ----------------------------------------------------------------------------
module gbba_bitmap_ram (
    input  logic                          clk,
    input  gbba_pkg::mem_req_t            req,
    output logic [gbba_pkg::WORD_BITS-1:0] rd_data
);
    import gbba_pkg::*;

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rd_data <= mem[req.addr];
    end

endmodule

[src/gbba_engine.sv]
// ----------------------------------------------------------------------------
// gbba_engine
// Sequencer: clearing pass, allocate scan, free divide and check, loads.
// ----------------------------------------------------------------------------
module gbba_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  gbba_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  gbba_pkg::in_item_t             in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output gbba_pkg::out_item_t            out_item,
    output gbba_pkg::mem_req_t             mem_req,
    input  logic [gbba_pkg::WORD_BITS-1:0] rd_data
);
    import gbba_pkg::*;

    localparam int BASE_W = TOT_W + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_AGRP  = 3'd2;
    localparam logic [2:0] S_ACHK  = 3'd3;
    localparam logic [2:0] S_FDIV  = 3'd4;
    localparam logic [2:0] S_FCHK  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic [NG_W-1:0]      g_reg, g_next;
    logic [WIDX_W-1:0]    w_reg, w_next;
    logic [BASE_W-1:0]    base_reg, base_next;
    logic [BASE_W-1:0]    wbase_reg, wbase_next;
    logic [TOT_W-1:0]     off_reg, off_next;
    logic [GCNT_W-1:0]    gcnt_reg [GROUPS];
    logic [TOT_W-1:0]     tot_reg, tot_next;
    logic [1:0]           st_reg, st_next;
    logic [TOT_W-1:0]     blk_reg, blk_next;
    logic                 out_valid_reg;
    out_item_t            out_item_reg;
    logic                 gcnt_we;
    logic [GRP_W-1:0]     gcnt_idx;
    logic [GCNT_W-1:0]    gcnt_wval;

    logic [GCNT_W-1:0]    bpg_eff;
    logic [NG_W-1:0]      ng_eff;
    logic                 accept;
    logic [GCNT_W:0]      wofs;
    logic [GCNT_W:0]      lim1;
    logic [BASE_W-1:0]    lim2;
    logic [BIT_W:0]       nv1, nv2, nvalid;
    logic [WORD_BITS-1:0] vmask, free_bits, first_bit;
    logic [BIT_W-1:0]     first_idx;
    logic [GCNT_W-1:0]    cur_cnt;
    logic                 out_load;

    assign bpg_eff = (cfg.group_size > GCNT_W'(BITS_PER_GROUP))
                   ? GCNT_W'(BITS_PER_GROUP) : cfg.group_size;
    assign ng_eff  = (cfg.groups_in_use > NG_W'(GROUPS)) ? NG_W'(GROUPS) : cfg.groups_in_use;
    assign accept  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cur_cnt = gcnt_reg[g_reg[GRP_W-1:0]];

    // valid bits of the current word
    assign wofs = (GCNT_W+1)'({w_reg, {BIT_W{1'b0}}});
    assign lim1 = ({1'b0, bpg_eff} > wofs) ? ({1'b0, bpg_eff} - wofs) : '0;
    assign lim2 = (BASE_W'(cfg.total_blocks) > wbase_reg)
                ? (BASE_W'(cfg.total_blocks) - wbase_reg) : '0;
    assign nv1  = (lim1 >= (GCNT_W+1)'(WORD_BITS)) ? (BIT_W+1)'(WORD_BITS) : lim1[BIT_W:0];
    assign nv2  = (lim2 >= BASE_W'(WORD_BITS)) ? (BIT_W+1)'(WORD_BITS) : lim2[BIT_W:0];
    assign nvalid = (nv1 < nv2) ? nv1 : nv2;

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            vmask[i] = ((BIT_W+1)'(i) < nvalid);
        end
    end

    assign free_bits = ~rd_data & vmask;
    assign first_bit = free_bits & (~free_bits + 1'b1);

    always_comb
    begin
        first_idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (first_bit[i])
            begin
                first_idx = first_idx | BIT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        g_next     = g_reg;
        w_next     = w_reg;
        base_next  = base_reg;
        wbase_next = wbase_reg;
        off_next   = off_reg;
        tot_next   = tot_reg;
        st_next    = st_reg;
        blk_next   = blk_reg;
        gcnt_we    = 1'b0;
        gcnt_idx   = g_reg[GRP_W-1:0];
        gcnt_wval  = cur_cnt;
        mem_req.we    = 1'b0;
        mem_req.addr  = {g_reg[GRP_W-1:0], w_reg};
        mem_req.wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_req.we   = 1'b1;
                mem_req.addr = clr_reg;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == {ADDR_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    st_next    = ST_DONE;
                    blk_next   = '0;
                    g_next     = '0;
                    w_next     = '0;
                    state_next = S_OUT;
                    case (in_item.kind)
                        KIND_ALLOC:
                        begin
                            base_next  = BASE_W'(cfg.data_start);
                            state_next = S_AGRP;
                        end
                        KIND_FREE:
                        begin
                            if (bpg_eff == '0
                                || in_item.block_number < TOT_W'(cfg.data_start)
                                || in_item.block_number >= cfg.total_blocks)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                off_next   = in_item.block_number
                                           - TOT_W'(cfg.data_start);
                                state_next = S_FDIV;
                            end
                        end
                        KIND_LOAD_WORD:
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.addr  = {in_item.group[GRP_W-1:0],
                                             in_item.word_index[WIDX_W-1:0]};
                            mem_req.wdata = in_item.load_value[WORD_BITS-1:0];
                        end
                        KIND_LOAD_GCNT:
                        begin
                            gcnt_we   = 1'b1;
                            gcnt_idx  = in_item.group[GRP_W-1:0];
                            gcnt_wval = in_item.load_value[GCNT_W-1:0];
                        end
                        KIND_LOAD_TOT:
                        begin
                            tot_next = in_item.load_value[TOT_W-1:0];
                        end
                        default:
                        begin
                            st_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_AGRP:
            begin
                mem_req.addr = {g_reg[GRP_W-1:0], {WIDX_W{1'b0}}};
                w_next       = '0;
                wbase_next   = base_reg;
                if (g_reg >= ng_eff)
                begin
                    st_next    = ST_NO_SPACE;
                    state_next = S_OUT;
                end
                else if (cur_cnt == '0)
                begin
                    base_next = base_reg + BASE_W'(bpg_eff);
                    g_next    = g_reg + 1'b1;
                end
                else
                begin
                    state_next = S_ACHK;
                end
            end
            S_ACHK:
            begin
                if (free_bits != '0)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = rd_data | first_bit;
                    gcnt_we       = 1'b1;
                    gcnt_wval     = (cur_cnt == '0) ? '0 : cur_cnt - 1'b1;
                    tot_next      = (tot_reg == '0) ? '0 : tot_reg - 1'b1;
                    blk_next      = TOT_W'(wbase_reg + BASE_W'(first_idx));
                    st_next       = ST_DONE;
                    state_next    = S_OUT;
                end
                else if (nvalid != (BIT_W+1)'(WORD_BITS) || w_reg == {WIDX_W{1'b1}})
                begin
                    base_next  = base_reg + BASE_W'(bpg_eff);
                    g_next     = g_reg + 1'b1;
                    state_next = S_AGRP;
                end
                else
                begin
                    w_next       = w_reg + 1'b1;
                    wbase_next   = wbase_reg + BASE_W'(WORD_BITS);
                    mem_req.addr = {g_reg[GRP_W-1:0], w_reg + 1'b1};
                end
            end
            S_FDIV:
            begin
                mem_req.addr = {g_reg[GRP_W-1:0], off_reg[BIT_W +: WIDX_W]};
                if (off_reg < TOT_W'(bpg_eff))
                begin
                    state_next = S_FCHK;
                end
                else if (g_reg == NG_W'(GROUPS - 1))
                begin
                    st_next    = ST_RANGE;
                    state_next = S_OUT;
                end
                else
                begin
                    off_next = off_reg - TOT_W'(bpg_eff);
                    g_next   = g_reg + 1'b1;
                end
            end
            S_FCHK:
            begin
                mem_req.addr = {g_reg[GRP_W-1:0], off_reg[BIT_W +: WIDX_W]};
                state_next   = S_OUT;
                if (rd_data[off_reg[BIT_W-1:0]])
                begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = rd_data & ~(WORD_BITS'(1) << off_reg[BIT_W-1:0]);
                    gcnt_we       = 1'b1;
                    gcnt_wval     = (cur_cnt == {GCNT_W{1'b1}}) ? cur_cnt : cur_cnt + 1'b1;
                    tot_next      = (tot_reg == {TOT_W{1'b1}}) ? tot_reg : tot_reg + 1'b1;
                    st_next       = ST_DONE;
                end
                else
                begin
                    st_next = ST_IS_FREE;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result waits here so the next item can start
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            tot_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < GROUPS; i++)
            begin
                gcnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            tot_reg   <= tot_next;
            if (gcnt_we)
            begin
                gcnt_reg[gcnt_idx] <= gcnt_wval;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg     <= g_next;
        w_reg     <= w_next;
        base_reg  <= base_next;
        wbase_reg <= wbase_next;
        off_reg   <= off_next;
        st_reg    <= st_next;
        blk_reg   <= blk_next;
        if (out_load)
        begin
            out_item_reg.status           <= st_reg;
            out_item_reg.block_number_res <= blk_reg;
            out_item_reg.total_free       <= tot_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

[src/grouped_bitmap_block_allocator.sv]
// ----------------------------------------------------------------------------
// grouped_bitmap_block_allocator
// Block allocator over per-group bitmaps with per-group and total free counts.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every word of the bitmap
// store and holds in_stall high meanwhile. Items are handled one at a time.
// Loads and out-of-range frees go straight to the result; any other free
// divides its offset one group per step, then reads the bitmap word and writes
// it back, and an allocate steps through the groups, reads the bitmap words of
// each group with free blocks one by one and then gives its result, all
// through the single bitmap read port. A finished result sits in an output
// register while the next item is taken.
module grouped_bitmap_block_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  gbba_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output gbba_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [gbba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gbba_pkg::TOT_W-1:0]          cfg_data
);
    import gbba_pkg::*;

    cfg_t                 cfg_reg;
    mem_req_t             mem_req;
    logic [WORD_BITS-1:0] rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.data_start    <= 1'b1;
            cfg_reg.group_size    <= GCNT_W'(BITS_PER_GROUP);
            cfg_reg.total_blocks  <= '0;
            cfg_reg.groups_in_use <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_DATA: cfg_reg.data_start    <= cfg_data[0];
                CFG_BPG:        cfg_reg.group_size    <= cfg_data[GCNT_W-1:0];
                CFG_TOTAL:      cfg_reg.total_blocks  <= cfg_data;
                CFG_GROUPS:     cfg_reg.groups_in_use <= cfg_data[NG_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    gbba_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    gbba_bitmap_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

[src/gbba_checker.sv]
// ----------------------------------------------------------------------------
// gbba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module gbba_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  gbba_pkg::out_item_t out_item
);
    import gbba_pkg::*;

    // result held while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result dropped or changed");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item taken while busy");

    // a failed item carries no block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != ST_DONE |-> out_item.block_number_res == '0)
        else $error("block number on failure");

    // a new result only follows an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without item");

endmodule

bind grouped_bitmap_block_allocator gbba_checker u_gbba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
